// ===== rtl/pwd_pkg.sv =====
// Shared types and constants for the peer wire message deframer.
package pwd_pkg;

  // Parser phase.
  typedef enum logic [2:0] {
    PH_LEN     = 3'd0,
    PH_TYPE    = 3'd1,
    PH_FIELDS  = 3'd2,
    PH_DATA    = 3'd3,
    PH_DISCARD = 3'd4
  } phase_e;

  // Result kind.
  typedef enum logic [1:0] {
    KIND_HEADER    = 2'd0,
    KIND_DATA      = 2'd1,
    KIND_KEEPALIVE = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_e;

  // Error code carried by an error result.
  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_HAVE_LEN    = 2'd1,
    ERR_REQ_LEN     = 2'd2,
    ERR_PIECE_SHORT = 2'd3
  } err_e;

  // Message type codes.
  localparam logic [7:0] TYPE_CHOKE          = 8'd0;
  localparam logic [7:0] TYPE_UNCHOKE        = 8'd1;
  localparam logic [7:0] TYPE_INTERESTED     = 8'd2;
  localparam logic [7:0] TYPE_NOT_INTERESTED = 8'd3;
  localparam logic [7:0] TYPE_HAVE           = 8'd4;
  localparam logic [7:0] TYPE_BITFIELD       = 8'd5;
  localparam logic [7:0] TYPE_REQUEST        = 8'd6;
  localparam logic [7:0] TYPE_PIECE          = 8'd7;
  localparam logic [7:0] TYPE_CANCEL         = 8'd8;

  // Payload lengths and field byte counts.
  localparam logic [31:0] HAVE_LEN      = 32'd4;
  localparam logic [31:0] REQ_LEN       = 32'd12;
  localparam logic [31:0] PIECE_HDR_LEN = 32'd8;
  localparam logic [3:0]  LEN_BYTES     = 4'd4;

  // One result beat.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  msg_type;
    logic [31:0] part_index;
    logic [31:0] begin_offset;
    logic [31:0] span_length;
    logic [7:0]  data_byte;
    logic        last;
    err_e        error_code;
    logic        remote_choking;
    logic        remote_interest;
  } res_t;

endpackage

// ===== rtl/pwd_parser.sv =====
// Message parser state and per-byte next-state and result logic.
module pwd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [7:0]       rx_byte_i,
  output logic             res_valid_o,
  output pwd_pkg::res_t    res_o
);

  pwd_pkg::phase_e phase_q, phase_d;
  logic [3:0]      cnt_q, cnt_d;
  logic [31:0]     msg_len_q, msg_len_d;
  logic [31:0]     rem_q, rem_d;
  logic [7:0]      type_q, type_d;
  logic [31:0]     idx_q, idx_d;
  logic [31:0]     off_q, off_d;
  logic [31:0]     rlen_q, rlen_d;
  logic            choked_q, choked_d;
  logic            wants_q, wants_d;
  logic            halted_q, halted_d;

  always_comb begin
    logic [31:0]    len_shift;
    logic [3:0]     cnt_inc;
    logic [31:0]    rem_dec;
    logic [31:0]    target;
    logic           emit_hdr;
    logic           emit_err;
    logic           emit_ka;
    logic           emit_data;
    pwd_pkg::err_e  err_code;

    phase_d   = phase_q;
    cnt_d     = cnt_q;
    msg_len_d = msg_len_q;
    rem_d     = rem_q;
    type_d    = type_q;
    idx_d     = idx_q;
    off_d     = off_q;
    rlen_d    = rlen_q;
    choked_d  = choked_q;
    wants_d   = wants_q;
    halted_d  = halted_q;
    len_shift = {msg_len_q[23:0], rx_byte_i};
    cnt_inc   = cnt_q + 4'd1;
    rem_dec   = rem_q - 32'd1;
    emit_hdr  = 1'b0;
    emit_err  = 1'b0;
    emit_ka   = 1'b0;
    emit_data = 1'b0;
    err_code  = pwd_pkg::ERR_NONE;

    if (type_q == pwd_pkg::TYPE_HAVE) begin
      target = pwd_pkg::HAVE_LEN;
    end else if (type_q == pwd_pkg::TYPE_PIECE) begin
      target = pwd_pkg::PIECE_HDR_LEN;
    end else begin
      target = pwd_pkg::REQ_LEN;
    end

    if (fire_i && !halted_q) begin
      unique case (phase_q)
        pwd_pkg::PH_LEN: begin
          msg_len_d = len_shift;
          if (cnt_inc < pwd_pkg::LEN_BYTES) begin
            cnt_d = cnt_inc;
          end else begin
            cnt_d = 4'd0;
            if (len_shift == 32'd0) begin
              emit_ka = 1'b1;
            end else begin
              rem_d   = len_shift - 32'd1;
              phase_d = pwd_pkg::PH_TYPE;
            end
          end
        end
        pwd_pkg::PH_TYPE: begin
          type_d = rx_byte_i;
          idx_d  = '0;
          off_d  = '0;
          rlen_d = '0;
          cnt_d  = 4'd0;
          case (rx_byte_i) inside
            pwd_pkg::TYPE_HAVE: begin
              if (rem_q != pwd_pkg::HAVE_LEN) begin
                emit_err = 1'b1;
                err_code = pwd_pkg::ERR_HAVE_LEN;
              end else begin
                phase_d = pwd_pkg::PH_FIELDS;
              end
            end
            pwd_pkg::TYPE_REQUEST, pwd_pkg::TYPE_CANCEL: begin
              if (rem_q != pwd_pkg::REQ_LEN) begin
                emit_err = 1'b1;
                err_code = pwd_pkg::ERR_REQ_LEN;
              end else begin
                phase_d = pwd_pkg::PH_FIELDS;
              end
            end
            pwd_pkg::TYPE_PIECE: begin
              if (rem_q < pwd_pkg::PIECE_HDR_LEN) begin
                emit_err = 1'b1;
                err_code = pwd_pkg::ERR_PIECE_SHORT;
              end else begin
                phase_d = pwd_pkg::PH_FIELDS;
              end
            end
            pwd_pkg::TYPE_BITFIELD: begin
              rlen_d   = rem_q;
              emit_hdr = 1'b1;
              phase_d  = (rem_q != 32'd0) ? pwd_pkg::PH_DATA : pwd_pkg::PH_LEN;
            end
            default: begin
              // Flag messages and unknown types: header now, payload dropped.
              if (rx_byte_i == pwd_pkg::TYPE_CHOKE) choked_d = 1'b1;
              if (rx_byte_i == pwd_pkg::TYPE_UNCHOKE) choked_d = 1'b0;
              if (rx_byte_i == pwd_pkg::TYPE_INTERESTED) wants_d = 1'b1;
              if (rx_byte_i == pwd_pkg::TYPE_NOT_INTERESTED) wants_d = 1'b0;
              emit_hdr = 1'b1;
              phase_d  = (rem_q != 32'd0) ? pwd_pkg::PH_DISCARD : pwd_pkg::PH_LEN;
            end
          endcase
          if (emit_err) begin
            halted_d = 1'b1;
          end
        end
        pwd_pkg::PH_FIELDS: begin
          if (cnt_q < 4'd4) begin
            idx_d = {idx_q[23:0], rx_byte_i};
          end else if (cnt_q < 4'd8) begin
            off_d = {off_q[23:0], rx_byte_i};
          end else begin
            rlen_d = {rlen_q[23:0], rx_byte_i};
          end
          cnt_d = cnt_inc;
          rem_d = rem_dec;
          if ({28'd0, cnt_inc} >= target) begin
            cnt_d    = 4'd0;
            emit_hdr = 1'b1;
            if (type_q == pwd_pkg::TYPE_PIECE) begin
              rlen_d  = rem_dec;
              phase_d = (rem_dec != 32'd0) ? pwd_pkg::PH_DATA : pwd_pkg::PH_LEN;
            end else begin
              phase_d = pwd_pkg::PH_LEN;
            end
          end
        end
        pwd_pkg::PH_DATA: begin
          rem_d     = rem_dec;
          emit_data = 1'b1;
          if (rem_dec == 32'd0) phase_d = pwd_pkg::PH_LEN;
        end
        pwd_pkg::PH_DISCARD: begin
          rem_d = rem_dec;
          if (rem_dec == 32'd0) phase_d = pwd_pkg::PH_LEN;
        end
        default: begin
          phase_d = pwd_pkg::PH_LEN;
          cnt_d   = 4'd0;
        end
      endcase
    end

    res_o                 = '0;
    res_o.kind            = pwd_pkg::KIND_HEADER;
    res_o.error_code      = pwd_pkg::ERR_NONE;
    if (emit_hdr || emit_data) begin
      res_o.kind         = emit_data ? pwd_pkg::KIND_DATA : pwd_pkg::KIND_HEADER;
      res_o.msg_type     = type_d;
      res_o.part_index   = idx_d;
      res_o.begin_offset = off_d;
      res_o.span_length  = rlen_d;
      res_o.data_byte    = emit_data ? rx_byte_i : 8'd0;
      res_o.last         = emit_data && (rem_dec == 32'd0);
    end else if (emit_err) begin
      res_o.kind       = pwd_pkg::KIND_ERROR;
      res_o.msg_type   = type_d;
      res_o.error_code = err_code;
    end else if (emit_ka) begin
      res_o.kind = pwd_pkg::KIND_KEEPALIVE;
    end
    res_o.remote_choking  = choked_d;
    res_o.remote_interest = wants_d;
    res_valid_o = emit_hdr || emit_data || emit_err || emit_ka;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= pwd_pkg::PH_LEN;
      cnt_q     <= 4'd0;
      msg_len_q <= '0;
      rem_q     <= '0;
      type_q    <= '0;
      idx_q     <= '0;
      off_q     <= '0;
      rlen_q    <= '0;
      choked_q  <= 1'b1;
      wants_q   <= 1'b0;
      halted_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      msg_len_q <= msg_len_d;
      rem_q     <= rem_d;
      type_q    <= type_d;
      idx_q     <= idx_d;
      off_q     <= off_d;
      rlen_q    <= rlen_d;
      choked_q  <= choked_d;
      wants_q   <= wants_d;
      halted_q  <= halted_d;
    end
  end

endmodule

// ===== rtl/peer_wire_message_deframer.sv =====
// Top level of the peer wire message deframer: input register, parser, result register.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         in_valid_i / in_stall_o   rx_byte_i
//   output   out        out_valid_o / out_stall_i kind_o .. remote_interest_o
//
// Each byte beat is captured in an input register and parsed from there; any result
// lands in the output register at the edge on which the parser takes that byte, so
// a result passes through both registers. One byte is taken every cycle as long as
// the output side keeps draining; the parser state update is the loop that sets
// this rate. A stalled result beat holds the output register, which in turn holds
// the input register and raises in_stall_o while a byte waits there.
// Reset puts the parser in the length phase with the peer choking flag set;
// after a length error the block swallows every byte until the next reset.
module peer_wire_message_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  msg_type_o,
  output logic [31:0] part_index_o,
  output logic [31:0] begin_offset_o,
  output logic [31:0] span_length_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o,
  output logic [1:0]  error_code_o,
  output logic        remote_choking_o,
  output logic        remote_interest_o
);

  // Input register holding the byte beat waiting to be parsed.
  logic          in_valid_q;
  logic [7:0]    rx_byte_q;

  // Output register holding the result beat offered downstream.
  logic          out_valid_q;
  pwd_pkg::res_t res_q;

  // Parser outputs for the byte in the input register.
  logic          res_valid;
  pwd_pkg::res_t res;

  logic          advance;
  logic          fire;

  // The output register can take a new value when it is empty or being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      rx_byte_q <= rx_byte_i;
    end
  end

  pwd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .rx_byte_i   (rx_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= fire && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && fire && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = res_q.kind;
  assign msg_type_o        = res_q.msg_type;
  assign part_index_o      = res_q.part_index;
  assign begin_offset_o    = res_q.begin_offset;
  assign span_length_o     = res_q.span_length;
  assign data_byte_o       = res_q.data_byte;
  assign last_o            = res_q.last;
  assign error_code_o      = res_q.error_code;
  assign remote_choking_o  = res_q.remote_choking;
  assign remote_interest_o = res_q.remote_interest;

endmodule

// ===== verif/tb_peer_wire_message_deframer.sv =====
// Self-checking testbench for the peer wire message deframer, with a byte-level predictor.
`timescale 1ns / 100ps

module tb_peer_wire_message_deframer;
  import pwd_pkg::*;

  // The watchdog limit is several times the slowest legal run: every byte behind the
  // longest sender gap and every beat behind the longest receiver stall.
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned LIVE_BYTE_GOAL = 1500;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned PRINT_CAP      = 50;

  // Type codes outside the defined set, used for the unknown-message case.
  localparam logic [7:0] TYPE_UNKNOWN_LOW  = 8'd9;
  localparam logic [7:0] TYPE_UNKNOWN_HIGH = 8'hFF;

  // Tracks the parser state as a byte stream goes in and holds the result beats
  // that the block owes, oldest first.
  class wire_msg_board;
    phase_e      stage;
    logic [3:0]  count;
    logic [31:0] frame_len;
    logic [31:0] left;
    logic [31:0] idx;
    logic [31:0] off;
    logic [31:0] span;
    logic [7:0]  cur_type;
    logic        choked;
    logic        interested;
    logic        stopped;
    res_t        awaited_beats[$];
    int unsigned mismatches;
    int unsigned beats_checked;
    int unsigned kind_seen[4];

    function new();
      stage         = PH_LEN;
      count         = '0;
      frame_len     = '0;
      left          = '0;
      idx           = '0;
      off           = '0;
      span          = '0;
      cur_type      = '0;
      choked        = 1'b1;
      interested    = 1'b0;
      stopped       = 1'b0;
      mismatches    = 0;
      beats_checked = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
    endfunction

    // Queues one expected beat; the flags are those after the current byte.
    function void expect_beat(kind_e k, logic [7:0] ty, logic [31:0] i, logic [31:0] o,
                              logic [31:0] s, logic [7:0] d, logic l, err_e e);
      res_t r;
      r.kind            = k;
      r.msg_type        = ty;
      r.part_index      = i;
      r.begin_offset    = o;
      r.span_length     = s;
      r.data_byte       = d;
      r.last            = l;
      r.error_code      = e;
      r.remote_choking  = choked;
      r.remote_interest = interested;
      awaited_beats.push_back(r);
    endfunction

    function void header();
      expect_beat(KIND_HEADER, cur_type, idx, off, span, 8'h00, 1'b0, ERR_NONE);
    endfunction

    // A bad payload length reports once and then freezes the parser for good.
    function void length_error(err_e e);
      stopped = 1'b1;
      expect_beat(KIND_ERROR, cur_type, '0, '0, '0, 8'h00, 1'b0, e);
    endfunction

    // Advances the parser by one accepted byte.
    function void take_byte(logic [7:0] b);
      int unsigned need;
      if (stopped) return;
      case (stage)
        PH_LEN: begin
          frame_len = {frame_len[23:0], b};
          count     = count + 1'b1;
          if (count >= LEN_BYTES) begin
            count = '0;
            if (frame_len == 0) begin
              expect_beat(KIND_KEEPALIVE, 8'h00, '0, '0, '0, 8'h00, 1'b0, ERR_NONE);
            end else begin
              left  = frame_len - 1;
              stage = PH_TYPE;
            end
          end
        end
        PH_TYPE: begin
          cur_type = b;
          idx      = '0;
          off      = '0;
          span     = '0;
          count    = '0;
          case (b)
            TYPE_HAVE: begin
              if (left != HAVE_LEN) length_error(ERR_HAVE_LEN);
              else stage = PH_FIELDS;
            end
            TYPE_REQUEST, TYPE_CANCEL: begin
              if (left != REQ_LEN) length_error(ERR_REQ_LEN);
              else stage = PH_FIELDS;
            end
            TYPE_PIECE: begin
              if (left < PIECE_HDR_LEN) length_error(ERR_PIECE_SHORT);
              else stage = PH_FIELDS;
            end
            TYPE_BITFIELD: begin
              span = left;
              header();
              stage = (left != 0) ? PH_DATA : PH_LEN;
            end
            default: begin
              // Flag messages update state; any other type only announces itself.
              if (b == TYPE_CHOKE) choked = 1'b1;
              else if (b == TYPE_UNCHOKE) choked = 1'b0;
              else if (b == TYPE_INTERESTED) interested = 1'b1;
              else if (b == TYPE_NOT_INTERESTED) interested = 1'b0;
              header();
              stage = (left != 0) ? PH_DISCARD : PH_LEN;
            end
          endcase
        end
        PH_FIELDS: begin
          if (count < 4) idx = {idx[23:0], b};
          else if (count < 8) off = {off[23:0], b};
          else span = {span[23:0], b};
          count = count + 1'b1;
          left  = left - 1;
          need  = (cur_type == TYPE_HAVE)  ? HAVE_LEN :
                  (cur_type == TYPE_PIECE) ? PIECE_HDR_LEN : REQ_LEN;
          if (count >= need) begin
            count = '0;
            if (cur_type == TYPE_PIECE) begin
              span  = left;
              stage = (left != 0) ? PH_DATA : PH_LEN;
            end else begin
              stage = PH_LEN;
            end
            header();
          end
        end
        PH_DATA: begin
          left = left - 1;
          expect_beat(KIND_DATA, cur_type, idx, off, span, b, left == 0, ERR_NONE);
          if (left == 0) stage = PH_LEN;
        end
        PH_DISCARD: begin
          left = left - 1;
          if (left == 0) stage = PH_LEN;
        end
        default: begin
          stage = PH_LEN;
          count = '0;
        end
      endcase
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("MISMATCH: %s", msg);
    endtask

    task check_field(string name, logic [31:0] got_v, logic [31:0] want_v);
      if (got_v !== want_v)
        report($sformatf("beat %0d %s: got 0x%0h, expected 0x%0h",
                         beats_checked, name, got_v, want_v));
    endtask

    task check_beat(res_t got);
      res_t want;
      if (awaited_beats.size() == 0) begin
        report($sformatf("result beat of kind %0d with none expected", got.kind));
        return;
      end
      want = awaited_beats.pop_front();
      beats_checked++;
      kind_seen[want.kind]++;
      check_field("kind", 32'(got.kind), 32'(want.kind));
      check_field("msg_type", 32'(got.msg_type), 32'(want.msg_type));
      check_field("part_index", got.part_index, want.part_index);
      check_field("begin_offset", got.begin_offset, want.begin_offset);
      check_field("span_length", got.span_length, want.span_length);
      check_field("data_byte", 32'(got.data_byte), 32'(want.data_byte));
      check_field("last", 32'(got.last), 32'(want.last));
      check_field("error_code", 32'(got.error_code), 32'(want.error_code));
      check_field("remote_choking", 32'(got.remote_choking), 32'(want.remote_choking));
      check_field("remote_interest", 32'(got.remote_interest),
                  32'(want.remote_interest));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  msg_type_o;
  logic [31:0] part_index_o;
  logic [31:0] begin_offset_o;
  logic [31:0] span_length_o;
  logic [7:0]  data_byte_o;
  logic        last_o;
  logic [1:0]  error_code_o;
  logic        remote_choking_o;
  logic        remote_interest_o;

  wire_msg_board board = new();

  // The frame under construction, sent byte by byte by send_frame.
  logic [7:0]  frame[$];
  int unsigned live_bytes    = 0;
  int unsigned frames_sent   = 0;
  int unsigned cycle_count   = 0;
  bit          sender_steady = 1'b0;
  bit          holdoff_req   = 1'b0;
  err_e        final_error   = ERR_NONE;

  peer_wire_message_deframer dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------------------
  // Frame building
  // ---------------------------------------------------------------------------

  function automatic void push_word(logic [31:0] w);
    for (int k = 3; k >= 0; k--) frame.push_back(w[8*k +: 8]);
  endfunction

  function automatic void open_frame(logic [31:0] len, logic [7:0] ty);
    frame.delete();
    push_word(len);
    frame.push_back(ty);
  endfunction

  function automatic void push_random(int unsigned n);
    repeat (n) frame.push_back(8'($urandom));
  endfunction

  // Field values lean on the extremes now and then.
  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Payload sizes stay small, with empty blocks and a few longer ones.
  function automatic int unsigned pick_block_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 90) return $urandom_range(1, 24);
    return $urandom_range(25, 80);
  endfunction

  // Payload the block is expected to throw away after a type byte.
  function automatic int unsigned pick_extra();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offers one beat after a random gap and returns at the edge that takes it.
  // Valid only drops when a gap is inserted, so it is never lowered and raised
  // within the same time step.
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    int unsigned r;
    if (sender_steady) begin
      gap = 0;
    end else begin
      r   = $urandom_range(0, 99);
      gap = (r < 65) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.take_byte(b);
  endtask

  // Sends the built frame; the trailing bytes that the block drops are not
  // counted toward the stimulus goal.
  task automatic send_frame(int unsigned dropped);
    if ($urandom_range(0, 7) == 0) sender_steady = !sender_steady;
    foreach (frame[k]) send_byte(frame[k]);
    live_bytes += frame.size() - dropped;
    frames_sent++;
  endtask

  task automatic tx_keepalive();
    frame.delete();
    push_word(32'h0);
    send_frame(0);
  endtask

  // Flag messages and unknown types: a type byte plus a payload that is dropped.
  task automatic send_plain(logic [7:0] ty, int unsigned extra);
    open_frame(1 + extra, ty);
    push_random(extra);
    send_frame(extra);
  endtask

  task automatic tx_have(logic [31:0] i);
    open_frame(1 + HAVE_LEN, TYPE_HAVE);
    push_word(i);
    send_frame(0);
  endtask

  task automatic tx_request(logic [7:0] ty, logic [31:0] i, logic [31:0] o, logic [31:0] l);
    open_frame(1 + REQ_LEN, ty);
    push_word(i);
    push_word(o);
    push_word(l);
    send_frame(0);
  endtask

  task automatic send_piece(logic [31:0] i, logic [31:0] o, int unsigned n);
    open_frame(1 + PIECE_HDR_LEN + n, TYPE_PIECE);
    push_word(i);
    push_word(o);
    push_random(n);
    send_frame(0);
  endtask

  task automatic tx_bitfield(int unsigned n);
    open_frame(1 + n, TYPE_BITFIELD);
    push_random(n);
    send_frame(0);
  endtask

  // Mostly well-formed messages with random content, plus unknown types.
  task automatic send_random_message();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) tx_keepalive();
    else if (r < 22) send_plain(8'($urandom_range(TYPE_CHOKE, TYPE_NOT_INTERESTED)), pick_extra());
    else if (r < 34) tx_have(pick_word());
    else if (r < 46) tx_request($urandom_range(0, 1) ? TYPE_REQUEST : TYPE_CANCEL,
                                pick_word(), pick_word(), pick_word());
    else if (r < 66) send_piece(pick_word(), pick_word(), pick_block_len());
    else if (r < 84) tx_bitfield(pick_block_len());
    else send_plain(8'($urandom_range(TYPE_UNKNOWN_LOW, TYPE_UNKNOWN_HIGH)), pick_extra());
  endtask

  // A length error halts the block until reset, and reset happens only once, so
  // exactly one such frame closes the stream. The length may be huge, since the
  // payload is never read. The bytes behind it, a keep-alive among them, must
  // produce nothing.
  task automatic send_length_error();
    logic [31:0] len;
    logic [31:0] good;
    logic [7:0]  ty;
    final_error = err_e'($urandom_range(ERR_HAVE_LEN, ERR_PIECE_SHORT));
    case (final_error)
      ERR_HAVE_LEN: begin
        ty   = TYPE_HAVE;
        good = 1 + HAVE_LEN;
      end
      ERR_REQ_LEN: begin
        ty   = $urandom_range(0, 1) ? TYPE_REQUEST : TYPE_CANCEL;
        good = 1 + REQ_LEN;
      end
      default: begin
        ty   = TYPE_PIECE;
        good = '0;
      end
    endcase
    if (ty == TYPE_PIECE) begin
      len = $urandom_range(1, PIECE_HDR_LEN);
    end else begin
      do begin
        len = $urandom_range(0, 1) ? 32'($urandom_range(1, 32)) : 32'($urandom);
      end while (len == 0 || len == good);
    end
    open_frame(len, ty);
    push_word(32'h0);
    push_random(8);
    send_frame(12);
  endtask

  // Drops valid and holds until the block has delivered everything it owes.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.awaited_beats.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side
  // ---------------------------------------------------------------------------

  // Random stalls, mostly short, sometimes long, with calm stretches of none.
  // A long hold-off requested by the stimulus is counted out here.
  initial begin : drain_control
    int unsigned r;
    bit          calm;
    calm = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk_i);
      end else if (!calm) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end else if (r < 17) begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(20, 60)) @(posedge clk_i);
        end
      end
      if ($urandom_range(0, 255) == 0) calm = !calm;
      out_stall_i <= 1'b0;
    end
  end

  // Every beat taken by the receiver is checked against the oldest expectation.
  always @(posedge clk_i) begin : result_monitor
    res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind            = kind_e'(kind_o);
      got.msg_type        = msg_type_o;
      got.part_index      = part_index_o;
      got.begin_offset    = begin_offset_o;
      got.span_length     = span_length_o;
      got.data_byte       = data_byte_o;
      got.last            = last_o;
      got.error_code      = err_e'(error_code_o);
      got.remote_choking  = remote_choking_o;
      got.remote_interest = remote_interest_o;
      board.check_beat(got);
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d beats still awaited.",
             cycle_count, board.awaited_beats.size());
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    bit holdoff_done;
    bit pause_done;
    holdoff_done = 1'b0;
    pause_done   = 1'b0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    rx_byte_i  <= 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: every message type, the flag updates, field extremes,
    // dropped payloads, empty bitfield and piece blocks, and keep-alives.
    tx_keepalive();
    send_plain(TYPE_UNCHOKE, 0);
    send_plain(TYPE_INTERESTED, 3);
    tx_have(32'hFFFF_FFFF);
    tx_have(32'h0000_0000);
    tx_bitfield(0);
    tx_bitfield(3);
    tx_request(TYPE_REQUEST, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_4000);
    tx_request(TYPE_CANCEL, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_piece(32'h1234_5678, 32'h0000_0000, 0);
    send_piece(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4);
    send_plain(TYPE_UNKNOWN_HIGH, 2);
    send_plain(TYPE_UNKNOWN_LOW, 0);
    send_plain(TYPE_NOT_INTERESTED, 0);
    send_plain(TYPE_CHOKE, 1);
    tx_keepalive();

    // Random part. A third of the way in the receiver holds off for a long
    // stretch while bytes keep coming, so the block backs up and stalls its
    // input; two thirds in the sender waits for the block to drain completely.
    while (live_bytes < LIVE_BYTE_GOAL) begin
      if (!holdoff_done && live_bytes > LIVE_BYTE_GOAL / 3) begin
        holdoff_req   = 1'b1;
        sender_steady = 1'b1;
        holdoff_done  = 1'b1;
      end
      if (!pause_done && live_bytes > 2 * LIVE_BYTE_GOAL / 3) begin
        wait_for_results();
        pause_done = 1'b1;
      end
      send_random_message();
    end

    send_length_error();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d frames (%0d parsed bytes); checked %0d beats: %0d headers, %0d data,",
             frames_sent, live_bytes, board.beats_checked, board.kind_seen[KIND_HEADER],
             board.kind_seen[KIND_DATA]);
    $display("%0d keep-alives, %0d errors; the stream closed on length error code %0d.",
             board.kind_seen[KIND_KEEPALIVE], board.kind_seen[KIND_ERROR], final_error);
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
